// ===== rtl/lfh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfh_pkg
// Types, constants and state codes shared by the letter frequency histogram.
// ----------------------------------------------------------------------------
package lfh_pkg;

    localparam int DEF_COUNT_BITS = 24;
    localparam int FIELD_BITS     = 24;
    localparam int NUM_BINS       = 26;
    localparam int BIN_BITS       = 5;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(NUM_BINS - 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_SORT_ORDER = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOLD_CASE  = 2'd1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } text_item_t;

    typedef struct packed {
        logic [BIN_BITS-1:0]   letter_index;
        logic [FIELD_BITS-1:0] letter_count;
        logic [FIELD_BITS-1:0] char_total;
        logic [FIELD_BITS-1:0] line_total;
        logic [FIELD_BITS-1:0] letter_total;
        logic                  last;
    } hist_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } lfh_state_t;

endpackage

// ===== rtl/letter_frequency_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_frequency_histogram
// Counts text bytes, newlines and letters; keeps a 26-bin letter histogram in
// a RAM updated by read-modify-write with forwarding; reports all bins in
// alphabetical or descending-count order.
// Data bytes: one per cycle while idle; bin write lands the cycle after.
// Report, alphabetical: each bin is read in ST_SCAN, compared in ST_FINISH
// and sent in ST_EMIT. Report, by count: per bin a 26-read scan of the bin
// RAM plus compare and emit. Input stalled during a report.
// Reset: all counts read as zero at once (per-bin valid flops), sort_order 0,
// fold_case 1.
// ----------------------------------------------------------------------------
module letter_frequency_histogram
#(
    parameter int COUNT_BITS = lfh_pkg::DEF_COUNT_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                text_valid,
    output logic                                text_stall,
    input  lfh_pkg::text_item_t                 text_item,
    output logic                                hist_valid,
    input  logic                                hist_stall,
    output lfh_pkg::hist_item_t                 hist_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic                                cfg_data
);

    import lfh_pkg::*;

    localparam int WIDE_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

    typedef logic [COUNT_BITS-1:0] count_t;

    function automatic count_t sat_inc(input count_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [FIELD_BITS-1:0] clamp_field(input count_t v);
        logic [WIDE_BITS-1:0] wide;
        wide = WIDE_BITS'(v);
        return (wide > WIDE_BITS'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}}
                                                        : wide[FIELD_BITS-1:0];
    endfunction

    lfh_state_t            state_reg, state_next;
    logic                  sort_order_reg, sort_order_next;
    logic                  fold_case_reg, fold_case_next;
    count_t                char_tally_reg, char_tally_next;
    count_t                line_tally_reg, line_tally_next;
    count_t                alpha_tally_reg, alpha_tally_next;
    logic [NUM_BINS-1:0]   filled_reg, filled_next;
    logic                  s2_inc_reg, s2_inc_next;
    logic                  fwd_valid_reg;
    logic [BIN_BITS-1:0]   fwd_addr_reg;
    count_t                fwd_data_reg;
    logic [BIN_BITS-1:0]   rd_addr_reg;
    logic                  sc_chk_reg, sc_chk_next;
    logic [BIN_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic [BIN_BITS-1:0]   pass_reg, pass_next;
    logic [NUM_BINS-1:0]   emitted_reg, emitted_next;
    logic                  best_found_reg, best_found_next;
    logic [BIN_BITS-1:0]   best_idx_reg, best_idx_next;
    count_t                best_cnt_reg, best_cnt_next;
    logic                  hist_valid_reg, hist_valid_next;
    hist_item_t            out_reg, out_next;

    logic                  text_xfer;
    logic                  is_data;
    logic                  is_lower;
    logic                  is_upper;
    logic                  is_newline;
    logic [7:0]            b;
    logic [BIN_BITS-1:0]   byte_bin;
    logic [BIN_BITS-1:0]   raddr;
    logic                  ram_we;
    count_t                ram_wdata;
    count_t                ram_rdata;
    count_t                rd_value;
    logic                  cand_first;

    lfh_ram
    #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    )
    u_bins
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rd_addr_reg),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign text_stall = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign hist_valid = hist_valid_reg;
    assign hist_item  = out_reg;

    assign text_xfer  = text_valid && !text_stall;
    assign is_data    = (text_item.kind == KIND_DATA);
    assign b          = text_item.byte_value;
    assign is_lower   = (b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z);
    assign is_upper   = (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z);
    assign is_newline = (b == CHAR_NEWLINE);
    assign byte_bin   = is_lower ? BIN_BITS'(b - CHAR_LOWER_A) : BIN_BITS'(b - CHAR_UPPER_A);
    assign raddr      = (state_reg == ST_IDLE) ? byte_bin : scan_idx_reg;

    assign rd_value   = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg :
                        (filled_reg[rd_addr_reg] ? ram_rdata : '0);
    assign ram_we     = s2_inc_reg;
    assign ram_wdata  = sat_inc(rd_value);
    assign cand_first = !best_found_reg || (rd_value > best_cnt_reg) ||
                        ((rd_value == best_cnt_reg) && (rd_addr_reg > best_idx_reg));

    always_comb
    begin
        state_next       = state_reg;
        sort_order_next  = sort_order_reg;
        fold_case_next   = fold_case_reg;
        char_tally_next  = char_tally_reg;
        line_tally_next  = line_tally_reg;
        alpha_tally_next = alpha_tally_reg;
        filled_next      = filled_reg;
        s2_inc_next      = 1'b0;
        sc_chk_next      = 1'b0;
        scan_idx_next    = scan_idx_reg;
        pass_next        = pass_reg;
        emitted_next     = emitted_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_cnt_next    = best_cnt_reg;
        hist_valid_next  = hist_valid_reg && hist_stall;
        out_next         = out_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SORT_ORDER)
            begin
                sort_order_next = cfg_data;
            end
            else if (cfg_index == REG_FOLD_CASE)
            begin
                fold_case_next = cfg_data;
            end
        end

        if (ram_we)
        begin
            filled_next[rd_addr_reg] = 1'b1;
        end

        if (sc_chk_reg && !emitted_reg[rd_addr_reg] && cand_first)
        begin
            best_found_next = 1'b1;
            best_idx_next   = rd_addr_reg;
            best_cnt_next   = rd_value;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (text_xfer)
                begin
                    if (is_data)
                    begin
                        char_tally_next = sat_inc(char_tally_reg);
                        if (is_newline)
                        begin
                            line_tally_next = sat_inc(line_tally_reg);
                        end
                        if (is_lower || is_upper)
                        begin
                            alpha_tally_next = sat_inc(alpha_tally_reg);
                        end
                        s2_inc_next = is_lower || (is_upper && fold_case_reg);
                    end
                    else
                    begin
                        pass_next       = '0;
                        scan_idx_next   = '0;
                        emitted_next    = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                sc_chk_next = 1'b1;
                if (!sort_order_reg || (scan_idx_reg == LAST_BIN))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!hist_valid_reg || !hist_stall)
                begin
                    hist_valid_next           = 1'b1;
                    out_next.letter_index     = best_idx_reg;
                    out_next.letter_count     = clamp_field(best_cnt_reg);
                    out_next.char_total       = clamp_field(char_tally_reg);
                    out_next.line_total       = clamp_field(line_tally_reg);
                    out_next.letter_total     = clamp_field(alpha_tally_reg);
                    out_next.last             = (pass_reg == LAST_BIN);
                    emitted_next[best_idx_reg] = 1'b1;
                    best_found_next           = 1'b0;
                    if (pass_reg == LAST_BIN)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pass_next     = pass_reg + 1'b1;
                        scan_idx_next = sort_order_reg ? '0 : pass_reg + 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sort_order_reg  <= 1'b0;
            fold_case_reg   <= 1'b1;
            char_tally_reg  <= '0;
            line_tally_reg  <= '0;
            alpha_tally_reg <= '0;
            filled_reg      <= '0;
            s2_inc_reg      <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            sc_chk_reg      <= 1'b0;
            scan_idx_reg    <= '0;
            pass_reg        <= '0;
            emitted_reg     <= '0;
            best_found_reg  <= 1'b0;
            hist_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sort_order_reg  <= sort_order_next;
            fold_case_reg   <= fold_case_next;
            char_tally_reg  <= char_tally_next;
            line_tally_reg  <= line_tally_next;
            alpha_tally_reg <= alpha_tally_next;
            filled_reg      <= filled_next;
            s2_inc_reg      <= s2_inc_next;
            fwd_valid_reg   <= ram_we;
            sc_chk_reg      <= sc_chk_next;
            scan_idx_reg    <= scan_idx_next;
            pass_reg        <= pass_next;
            emitted_reg     <= emitted_next;
            best_found_reg  <= best_found_next;
            hist_valid_reg  <= hist_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= raddr;
        fwd_addr_reg <= rd_addr_reg;
        fwd_data_reg <= ram_wdata;
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
        out_reg      <= out_next;
    end

endmodule

// ===== rtl/lfh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfh_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 26
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lfh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfh_assertions
// Port-level checks of the letter frequency histogram, bound to the top level.
// ----------------------------------------------------------------------------
module lfh_assertions
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                text_valid,
    input  logic                                text_stall,
    input  lfh_pkg::text_item_t                 text_item,
    input  logic                                hist_valid,
    input  logic                                hist_stall,
    input  lfh_pkg::hist_item_t                 hist_item,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lfh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic                                cfg_data
);

    import lfh_pkg::*;

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
        else $error("register write not taken or carries unknown bits");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        hist_valid && hist_stall |=> hist_valid && $stable(hist_item))
        else $error("stalled bin transfer changed");

    a_report_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall && (text_item.kind == KIND_REPORT) |=> text_stall)
        else $error("input not stalled after report request");

    a_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        hist_valid && !hist_item.last |-> text_stall)
        else $error("input accepted in the middle of a report");

    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        hist_valid |-> (hist_item.letter_count <= hist_item.letter_total) &&
                       (hist_item.letter_total <= hist_item.char_total) &&
                       (hist_item.line_total <= hist_item.char_total))
        else $error("bin count or totals inconsistent");

endmodule

bind letter_frequency_histogram lfh_assertions u_lfh_assertions (.*);

// ===== bench/lfh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfh_checker
// Watches the text, histogram and register channels of the letter frequency
// histogram. It keeps its own copy of the counters and registers, works out
// the 26 bins of every report as transfers are accepted, and compares each
// histogram transfer field by field with the oldest expected bin.
// ----------------------------------------------------------------------------
module lfh_checker
#(
    parameter int COUNT_BITS = lfh_pkg::DEF_COUNT_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               text_valid,
    input  logic                               text_stall,
    input  lfh_pkg::text_item_t                text_item,
    input  logic                               hist_valid,
    input  logic                               hist_stall,
    input  lfh_pkg::hist_item_t                hist_item,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [lfh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic                               cfg_data,
    output int                                 mismatches,
    output int                                 expected_left,
    output int                                 bins_checked
);

    import lfh_pkg::*;

    localparam logic [63:0] FIELD_MAX = (64'd1 << FIELD_BITS) - 64'd1;

    logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
    logic [COUNT_BITS-1:0] byte_tally;
    logic [COUNT_BITS-1:0] newline_tally;
    logic [COUNT_BITS-1:0] alpha_tally;
    logic                  sort_by_count;
    logic                  fold_upper;
    hist_item_t            bins_due [$];

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [COUNT_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > FIELD_MAX) ? FIELD_MAX[FIELD_BITS-1:0] : wide[FIELD_BITS-1:0];
    endfunction

    function automatic bit ranks_ahead(input int a, input int b);
        if (bin_tally[a] != bin_tally[b])
            return bin_tally[a] > bin_tally[b];
        return a > b;
    endfunction

    task automatic count_byte(input logic [7:0] b);
        logic [BIN_BITS-1:0] bin;
        byte_tally = bump(byte_tally);
        if (b == CHAR_NEWLINE)
            newline_tally = bump(newline_tally);
        if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
        begin
            bin = BIN_BITS'(b - CHAR_LOWER_A);
            alpha_tally = bump(alpha_tally);
            bin_tally[bin] = bump(bin_tally[bin]);
        end
        else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            bin = BIN_BITS'(b - CHAR_UPPER_A);
            alpha_tally = bump(alpha_tally);
            if (fold_upper)
                bin_tally[bin] = bump(bin_tally[bin]);
        end
    endtask

    task automatic queue_report();
        int         order [NUM_BINS];
        int         v;
        int         j;
        hist_item_t h;
        for (int i = 0; i < NUM_BINS; i++)
            order[i] = i;
        if (sort_by_count)
        begin
            for (int i = 1; i < NUM_BINS; i++)
            begin
                v = order[i];
                j = i;
                while (j > 0 && ranks_ahead(v, order[j-1]))
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = v;
            end
        end
        for (int i = 0; i < NUM_BINS; i++)
        begin
            h.letter_index = BIN_BITS'(order[i]);
            h.letter_count = clamp_field(bin_tally[order[i]]);
            h.char_total   = clamp_field(byte_tally);
            h.line_total   = clamp_field(newline_tally);
            h.letter_total = clamp_field(alpha_tally);
            h.last         = (i == NUM_BINS - 1);
            bins_due = {bins_due, h};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hist_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
                bin_tally[i] = '0;
            byte_tally    = '0;
            newline_tally = '0;
            alpha_tally   = '0;
            sort_by_count = 1'b0;
            fold_upper    = 1'b1;
            bins_due.delete();
            mismatches    = 0;
            expected_left = 0;
            bins_checked  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SORT_ORDER: sort_by_count = cfg_data;
                    REG_FOLD_CASE:  fold_upper = cfg_data;
                    default: ;
                endcase
            end
            if (text_valid && !text_stall)
            begin
                if (text_item.kind == KIND_REPORT)
                    queue_report();
                else
                    count_byte(text_item.byte_value);
            end
            if (hist_valid && !hist_stall)
            begin
                if (bins_due.size() == 0)
                begin
                    $error("histogram transfer with no bin expected: letter_index %0d",
                           hist_item.letter_index);
                    mismatches++;
                end
                else
                begin
                    want = bins_due.pop_front();
                    check_field("letter_index", 32'(want.letter_index),
                                32'(hist_item.letter_index));
                    check_field("letter_count", 32'(want.letter_count),
                                32'(hist_item.letter_count));
                    check_field("char_total", 32'(want.char_total),
                                32'(hist_item.char_total));
                    check_field("line_total", 32'(want.line_total),
                                32'(hist_item.line_total));
                    check_field("letter_total", 32'(want.letter_total),
                                32'(hist_item.letter_total));
                    check_field("last", 32'(want.last), 32'(hist_item.last));
                    bins_checked++;
                end
            end
            expected_left = bins_due.size();
        end
    end

endmodule

// ===== bench/letter_frequency_histogram_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_frequency_histogram_tb
// Drives text bytes and report requests into the histogram block under random
// sender gaps and receiver stalls, cycles through every sort and case-folding
// setting between phases, and lets lfh_checker predict and compare every bin.
// ----------------------------------------------------------------------------
module letter_frequency_histogram_tb;

    import lfh_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         END_CYCLES    = 40;
    localparam int         PHASES        = 6;
    localparam int         PHASE_ITEMS   = 44;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      text_valid = 1'b0;
    text_item_t                text_item  = '0;
    logic                      hist_stall = 1'b0;
    logic                      cfg_valid  = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic                      cfg_data   = 1'b0;
    logic                      text_stall;
    logic                      hist_valid;
    logic                      cfg_ready;
    hist_item_t                hist_item;

    int mismatches;
    int expected_left;
    int bins_checked;
    int idle_pct     = 0;
    int stall_left   = 0;
    int items_sent   = 0;
    int reports_sent = 0;

    letter_frequency_histogram u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item),
        .hist_valid (hist_valid),
        .hist_stall (hist_stall),
        .hist_item  (hist_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    lfh_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_item     (text_item),
        .hist_valid    (hist_valid),
        .hist_stall    (hist_stall),
        .hist_item     (hist_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .expected_left (expected_left),
        .bins_checked  (bins_checked)
    );

    always #5 clk = ~clk;

    // receiver stalls in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            hist_stall <= (stall_left > 1);
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left <= $urandom_range(1, 7);
            hist_stall <= 1'b1;
        end
        else
            hist_stall <= 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("letter_frequency_histogram_tb: FAIL");
        $finish;
    end

    task automatic send_text(input logic item_kind, input logic [7:0] value);
        text_item_t t;
        t.kind       = item_kind;
        t.byte_value = value;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= t;
        @(posedge clk);
        while (text_stall) @(posedge clk);
        items_sent++;
        if (item_kind == KIND_REPORT)
            reports_sent++;
    endtask

    task automatic drain(input int settle);
        text_valid <= 1'b0;
        @(negedge clk);
        while (expected_left != 0) @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CHAR_LOWER_A + 8'($urandom_range(0, 5));
        if (r < 50)
            return CHAR_LOWER_A + 8'($urandom_range(0, 25));
        if (r < 70)
            return CHAR_UPPER_A + 8'($urandom_range(0, 25));
        if (r < 78)
            return CHAR_NEWLINE;
        if (r < 85)
            return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        send_text(KIND_REPORT, 8'h00);
        send_text(KIND_DATA, CHAR_LOWER_A);
        send_text(KIND_DATA, CHAR_LOWER_Z);
        send_text(KIND_DATA, CHAR_UPPER_A);
        send_text(KIND_DATA, CHAR_UPPER_Z);
        send_text(KIND_DATA, CHAR_NEWLINE);
        send_text(KIND_DATA, 8'h00);
        send_text(KIND_DATA, 8'hFF);
        send_text(KIND_DATA, 8'h80);
        send_text(KIND_DATA, CHAR_UPPER_A - 8'd1);
        send_text(KIND_DATA, CHAR_UPPER_Z + 8'd1);
        send_text(KIND_DATA, CHAR_LOWER_A - 8'd1);
        send_text(KIND_DATA, CHAR_LOWER_Z + 8'd1);
        send_text(KIND_REPORT, 8'hFF);

        drain(SETTLE_CYCLES);
        write_reg(REG_SORT_ORDER, 1'b1);
        send_text(KIND_REPORT, CHAR_LOWER_A);

        drain(SETTLE_CYCLES);
        write_reg(REG_FOLD_CASE, 1'b0);
        send_text(KIND_DATA, CHAR_UPPER_A + 8'd1);
        send_text(KIND_DATA, CHAR_LOWER_A + 8'd1);
        send_text(KIND_DATA, CHAR_UPPER_A + 8'd12);
        send_text(KIND_DATA, CHAR_NEWLINE);
        send_text(KIND_REPORT, CHAR_NEWLINE);

        drain(SETTLE_CYCLES);
        write_reg(REG_SPARE_2, 1'b1);
        write_reg(REG_SPARE_3, 1'b1);
        send_text(KIND_REPORT, 8'h55);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain(SETTLE_CYCLES);
            if (ph < 4)
            begin
                write_reg(REG_SORT_ORDER, (ph == 1 || ph == 2));
                write_reg(REG_FOLD_CASE, (ph == 1 || ph == 3));
            end
            else
            begin
                write_reg(REG_SORT_ORDER, 1'($urandom_range(0, 1)));
                write_reg(REG_FOLD_CASE, 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_SPARE_3, 1'($urandom_range(0, 1)));
            idle_pct = (ph == 2 || ph == PHASES - 1) ? 0 : 30;
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_text(KIND_REPORT, 8'($urandom_range(0, 255)));
                else
                    send_text(KIND_DATA, pick_text_byte());
            end
            send_text(KIND_REPORT, 8'($urandom_range(0, 255)));
        end

        drain(END_CYCLES);
        $display("letter_frequency_histogram_tb: %0d text transfers, %0d report requests,",
                 items_sent, reports_sent);
        $display("letter_frequency_histogram_tb: %0d bins compared over all sort/fold settings",
                 bins_checked);
        if (mismatches == 0)
            $display("letter_frequency_histogram_tb: PASS");
        else
            $display("letter_frequency_histogram_tb: FAIL");
        $finish;
    end

endmodule
